// ----- hdl/ccbu_pkg.sv -----
// Shared types and constants of the point centering / bond unit vector block.
// No dependencies; every module of the block imports this package.
`default_nettype none

package ccbu_pkg;

    // field and datapath widths
    localparam int CW      = 13;  // point count and point limit
    localparam int COORD_W = 25;  // one coordinate
    localparam int IDX_W   = 12;  // fetch index
    localparam int DIFF_W  = 26;  // bond component
    localparam int MAG_W   = 25;  // magnitude of a bond component
    localparam int SQ_W    = 50;  // square of a bond component
    localparam int LEN_W   = 52;  // squared bond length
    localparam int SUM_W   = 38;  // coordinate sum
    localparam int DVD_W   = 39;  // centering dividend 2*|sum| + count
    localparam int REM_W   = 53;  // divider partial remainder
    localparam int ROOT_W  = 31;  // square root working registers
    localparam int STEP_W  = 6;   // controller step counter
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // iteration counts
    localparam logic [STEP_W-1:0] DIV_STEPS_CTR  = 6'd39;
    localparam logic [STEP_W-1:0] DIV_STEPS_BOND = 6'd31;
    localparam logic [STEP_W-1:0] SQRT_STEPS     = 6'd16;
    localparam logic [STEP_W-1:0] SQ_LAST        = 6'd3;

    localparam logic [ROOT_W-1:0] ROOT_BIT0 = 31'h4000_0000;

    // request and mode codes
    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_FETCH   = 1'b1;
    localparam logic MODE_CENTER = 1'b0;
    localparam logic MODE_BOND   = 1'b1;

    // register map (index taken from paddr bit 2)
    localparam logic REG_MODE       = 1'b0;
    localparam logic REG_MAX_POINTS = 1'b1;
    localparam logic [CW-1:0] MAX_POINTS_RST = 13'd4096;

    typedef struct packed {
        logic               req_type;
        logic               first;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] pz;
        logic [IDX_W-1:0]   fetch_index;
    } ccbu_in_t;

    typedef struct packed {
        logic               valid_res;
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic [COORD_W-1:0] oz;
    } ccbu_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RD1,
        ST_RD2,
        ST_SQ,
        ST_LEN,
        ST_DIV,
        ST_SQI,
        ST_SQRT,
        ST_DONE
    } ccbu_state_t;

    typedef struct packed {
        logic       load;
        logic       fetch;
        logic       rd_en;
        logic       rd_next;
        logic       cap_a;
        logic       cap_diff;
        logic       sq_en;
        logic [1:0] sq_sel;
        logic       acc_en;
        logic [1:0] acc_sel;
        logic       div_init;
        logic       div_step;
        logic       div_noshift;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       out_load;
        logic       out_valid;
        logic       out_zero;
    } ccbu_cmd_t;

    typedef struct packed {
        logic fetch_ok;
        logic len_zero;
        logic out_free;
        logic mode;
    } ccbu_status_t;

endpackage

`default_nettype wire

// ----- hdl/coord_centering_bond_unit_vectors_top.sv -----
// A load is taken while the controller is idle. An out-of-range fetch index gives
// a zero result after the range check, as does a zero bond length after the squarer.
// Otherwise a fetch passes the 39-step divider in centering mode, and the squarer,
// 31-step divider and 16-step root in bond mode. One fetch is in flight at a time.
// Reset (aresetn low, synchronous) empties the store and sums; no clearing pass.
// Top level: configuration registers and the controller/datapath pair. Depends on ccbu_pkg.
`default_nettype none

module coord_centering_bond_unit_vectors_top import ccbu_pkg::*; #(
    parameter int CAPACITY = 4096
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ccbu_in_t           s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output ccbu_out_t               m_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    logic          mode_reg;
    logic [CW-1:0] max_points_reg;
    logic          wr_en;
    ccbu_cmd_t     cmd;
    ccbu_status_t  status;

    // configuration registers
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_CENTER;
            max_points_reg <= MAX_POINTS_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_MODE:       mode_reg       <= pwdata[0];
                REG_MAX_POINTS: max_points_reg <= pwdata[CW-1:0];
                default:        mode_reg       <= mode_reg;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_MAX_POINTS) ? PDATA_W'(max_points_reg)
                                                 : PDATA_W'(mode_reg);

    ccbu_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_is_fetch (s_data.req_type == REQ_FETCH),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    ccbu_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_data     (s_data),
        .cmd        (cmd),
        .mode       (mode_reg),
        .max_points (max_points_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .status     (status)
    );

endmodule

`default_nettype wire

// ----- hdl/ccbu_ctrl.sv -----
// Sequencing state machine of the point centering / bond unit vector block.
// Depends on ccbu_pkg; drives the datapath through ccbu_cmd_t.
`default_nettype none

module ccbu_ctrl import ccbu_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    input  wire logic         in_is_fetch,
    output logic              s_ready,
    input  wire ccbu_status_t status,
    output ccbu_cmd_t         cmd
);

    ccbu_state_t       state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              valid_reg, valid_next;
    logic              zero_reg, zero_next;
    logic [STEP_W-1:0] div_last;

    assign div_last = ((status.mode == MODE_BOND) ? DIV_STEPS_BOND : DIV_STEPS_CTR) - 6'd1;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
            zero_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            zero_reg  <= zero_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        zero_next  = zero_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (in_valid) begin
                    if (in_is_fetch) begin
                        cmd.fetch  = 1'b1;
                        state_next = ST_CHECK;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                if (status.fetch_ok) begin
                    cmd.rd_en  = 1'b1;
                    valid_next = 1'b1;
                    zero_next  = 1'b0;
                    state_next = ST_RD1;
                end else begin
                    valid_next = 1'b0;
                    zero_next  = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_RD1: begin
                cmd.cap_a = 1'b1;
                cnt_next  = '0;
                if (status.mode == MODE_CENTER) begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = ST_RD2;
                end
            end
            ST_RD2: begin
                cmd.cap_diff = 1'b1;
                cnt_next     = '0;
                state_next   = ST_SQ;
            end
            ST_SQ: begin
                // square one component while the previous square accumulates
                cmd.sq_en   = (cnt_reg < SQ_LAST);
                cmd.sq_sel  = cnt_reg[1:0];
                cmd.acc_en  = (cnt_reg != '0);
                cmd.acc_sel = cnt_reg[1:0] - 2'd1;
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == SQ_LAST) begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                if (status.len_zero) begin
                    zero_next  = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step    = 1'b1;
                cmd.div_noshift = (status.mode == MODE_BOND) && (cnt_reg == '0);
                cnt_next        = cnt_reg + 6'd1;
                if (cnt_reg == div_last) begin
                    state_next = (status.mode == MODE_BOND) ? ST_SQI : ST_DONE;
                end
            end
            ST_SQI: begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == SQRT_STEPS - 6'd1) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register can take the result
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_valid = valid_reg;
                    cmd.out_zero  = zero_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg < DIV_STEPS_CTR))
        else $error("divider step count out of range");
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over an untaken result");
    a_fetch_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && s_ready && in_is_fetch) |=> (state_reg == ST_CHECK))
        else $error("fetch transfer did not start a check");
`endif

endmodule

`default_nettype wire

// ----- hdl/ccbu_dp.sv -----
// Datapath: point memories, sums, squarer, three divider lanes, three root lanes.
// Depends on ccbu_pkg; controlled by ccbu_ctrl through ccbu_cmd_t.
`default_nettype none

module ccbu_dp import ccbu_pkg::*; #(
    parameter int CAPACITY = 4096
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire ccbu_in_t     s_data,
    input  wire ccbu_cmd_t    cmd,
    input  wire logic         mode,
    input  wire logic [CW-1:0] max_points,
    output logic              m_valid,
    input  wire logic         m_ready,
    output ccbu_out_t         m_data,
    output ccbu_status_t      status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP_LIM = (CAPACITY > 8191) ? {CW{1'b1}} : CW'(CAPACITY);

    // point memories
    logic [COORD_W-1:0] mem_x [CAPACITY];
    logic [COORD_W-1:0] mem_y [CAPACITY];
    logic [COORD_W-1:0] mem_z [CAPACITY];

    logic [CW-1:0]                  count_reg, count_next;
    logic [2:0][SUM_W-1:0]          sum_reg, sum_next;
    logic [2:0][COORD_W-1:0]        in_pt;
    logic [CW-1:0]                  base_cnt, limit;
    logic                           store_ok;
    logic [AW-1:0]                  wr_addr, rd_addr;

    logic [IDX_W-1:0]               idx_reg;
    logic [CW-1:0]                  idx_p1;
    logic [2:0][COORD_W-1:0]        rd_reg;
    logic [2:0][COORD_W-1:0]        a_reg;
    logic [2:0][DIFF_W-1:0]         d_reg;
    logic [2:0][MAG_W-1:0]          dmag;
    logic [MAG_W-1:0]               sq_op;
    logic [SQ_W-1:0]                sq_reg;
    logic [2:0][SQ_W-1:0]           num_reg;
    logic [LEN_W-1:0]               len2_reg;

    logic [REM_W-1:0]               divisor_reg;
    logic [2:0][REM_W-1:0]          rem_reg;
    logic [2:0][DVD_W-1:0]          dvd_reg;
    logic [2:0][DVD_W-1:0]          quo_reg;
    logic [2:0]                     sgn_reg;
    logic [2:0][REM_W-1:0]          cand;
    logic [2:0]                     ge;
    logic [2:0][SUM_W-1:0]          mag_sum;

    logic [2:0][ROOT_W-1:0]         v_reg;
    logic [2:0][ROOT_W-1:0]         res_reg;
    logic [ROOT_W-1:0]              bit_reg;
    logic [2:0][ROOT_W:0]           trial;
    logic [2:0]                     rge;

    logic [2:0][COORD_W-1:0]        res_out;
    logic                           m_valid_reg;
    ccbu_out_t                      m_data_reg;

    assign in_pt[0] = s_data.px;
    assign in_pt[1] = s_data.py;
    assign in_pt[2] = s_data.pz;

    // load: clear on first, drop beyond the limit
    assign limit    = (max_points < CAP_LIM) ? max_points : CAP_LIM;
    assign base_cnt = s_data.first ? '0 : count_reg;
    assign store_ok = (base_cnt < limit);
    assign wr_addr  = AW'(base_cnt);

    always_comb begin
        count_next = store_ok ? (base_cnt + 13'd1) : base_cnt;
        for (int l = 0; l < 3; l++) begin
            sum_next[l] = s_data.first ? '0 : sum_reg[l];
            if (store_ok) begin
                sum_next[l] = sum_next[l]
                            + {{(SUM_W-COORD_W){in_pt[l][COORD_W-1]}}, in_pt[l]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
        end else if (cmd.load) begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    // memory write and registered read
    assign idx_p1  = {1'b0, idx_reg} + 13'd1;
    assign rd_addr = cmd.rd_next ? AW'(idx_p1) : AW'(idx_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load && store_ok) begin
            mem_x[wr_addr] <= in_pt[0];
            mem_y[wr_addr] <= in_pt[1];
            mem_z[wr_addr] <= in_pt[2];
        end
        if (cmd.rd_en) begin
            rd_reg[0] <= mem_x[rd_addr];
            rd_reg[1] <= mem_y[rd_addr];
            rd_reg[2] <= mem_z[rd_addr];
        end
    end

    // fetch index and range check
    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            idx_reg <= s_data.fetch_index;
        end
    end

    assign status.fetch_ok = (mode == MODE_CENTER) ? ({1'b0, idx_reg} < count_reg)
                                                   : (idx_p1 < count_reg);
    assign status.len_zero = (len2_reg == '0);
    assign status.out_free = !m_valid_reg || m_ready;
    assign status.mode     = mode;

    // component magnitudes for the squarer and the dividers
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            dmag[l]    = d_reg[l][DIFF_W-1] ? MAG_W'(-d_reg[l]) : d_reg[l][MAG_W-1:0];
            mag_sum[l] = sum_reg[l][SUM_W-1] ? -sum_reg[l] : sum_reg[l];
        end
    end
    assign sq_op = dmag[cmd.sq_sel];

    // point capture, differences, squares and squared length
    always_ff @(posedge aclk) begin
        if (cmd.cap_a) begin
            a_reg <= rd_reg;
        end
        if (cmd.cap_diff) begin
            for (int l = 0; l < 3; l++) begin
                d_reg[l] <= {rd_reg[l][COORD_W-1], rd_reg[l]}
                          - {a_reg[l][COORD_W-1], a_reg[l]};
            end
            len2_reg <= '0;
        end else if (cmd.acc_en) begin
            len2_reg <= len2_reg + LEN_W'(sq_reg);
        end
        if (cmd.sq_en) begin
            sq_reg <= SQ_W'(sq_op) * SQ_W'(sq_op);
        end
        if (cmd.acc_en) begin
            num_reg[cmd.acc_sel] <= sq_reg;
        end
    end

    // restoring divider step, one quotient bit per lane
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            cand[l] = cmd.div_noshift ? rem_reg[l]
                                      : {rem_reg[l][REM_W-2:0], dvd_reg[l][DVD_W-1]};
            ge[l]   = (cand[l] >= divisor_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            if (mode == MODE_CENTER) begin
                divisor_reg <= REM_W'({count_reg, 1'b0});
            end else begin
                divisor_reg <= REM_W'(len2_reg);
            end
            for (int l = 0; l < 3; l++) begin
                quo_reg[l] <= '0;
                if (mode == MODE_CENTER) begin
                    rem_reg[l] <= '0;
                    dvd_reg[l] <= {mag_sum[l], 1'b0} + DVD_W'(count_reg);
                    sgn_reg[l] <= sum_reg[l][SUM_W-1];
                end else begin
                    rem_reg[l] <= REM_W'(num_reg[l]);
                    dvd_reg[l] <= '0;
                    sgn_reg[l] <= d_reg[l][DIFF_W-1];
                end
            end
        end else if (cmd.div_step) begin
            for (int l = 0; l < 3; l++) begin
                rem_reg[l] <= ge[l] ? (cand[l] - divisor_reg) : cand[l];
                quo_reg[l] <= {quo_reg[l][DVD_W-2:0], ge[l]};
                dvd_reg[l] <= {dvd_reg[l][DVD_W-2:0], 1'b0};
            end
        end
    end

    // integer square root, two bits of radicand per step
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            trial[l] = {1'b0, res_reg[l]} + {1'b0, bit_reg};
            rge[l]   = ({1'b0, v_reg[l]} >= trial[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_init) begin
            bit_reg <= ROOT_BIT0;
            for (int l = 0; l < 3; l++) begin
                v_reg[l]   <= quo_reg[l][ROOT_W-1:0];
                res_reg[l] <= '0;
            end
        end else if (cmd.sqrt_step) begin
            bit_reg <= bit_reg >> 2;
            for (int l = 0; l < 3; l++) begin
                if (rge[l]) begin
                    v_reg[l]   <= v_reg[l] - trial[l][ROOT_W-1:0];
                    res_reg[l] <= (res_reg[l] >> 1) + bit_reg;
                end else begin
                    res_reg[l] <= res_reg[l] >> 1;
                end
            end
        end
    end

    // result selection: centered point, signed unit component, or zero
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (cmd.out_zero) begin
                res_out[l] = '0;
            end else if (mode == MODE_CENTER) begin
                res_out[l] = a_reg[l] - (sgn_reg[l] ? -quo_reg[l][COORD_W-1:0]
                                                    : quo_reg[l][COORD_W-1:0]);
            end else begin
                res_out[l] = sgn_reg[l] ? -res_reg[l][COORD_W-1:0]
                                        : res_reg[l][COORD_W-1:0];
            end
        end
    end

    // output register; drop valid once the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.valid_res <= cmd.out_valid;
            m_data_reg.ox        <= res_out[0];
            m_data_reg.oy        <= res_out[1];
            m_data_reg.oz        <= res_out[2];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_LIM)
        else $error("point count beyond capacity");
    a_first_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && s_data.first && store_ok) |=> (count_reg == 13'd1))
        else $error("first load did not restart the count");
    a_root_init: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sqrt_init |=> (bit_reg == ROOT_BIT0))
        else $error("root lanes not initialized");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_coord_centering_bond_unit_vectors_top.sv -----
// Testbench of coord_centering_bond_unit_vectors_top: point loads and fetches
// with a self-predicting scoreboard, APB register setup and random stalls.
// Depends on ccbu_pkg and the block's RTL only.
`default_nettype none

module tb_coord_centering_bond_unit_vectors_top import ccbu_pkg::*;;

    localparam int DEPTH       = 4096;
    localparam int IDLE_LIMIT  = 4000;
    localparam int SETTLE      = 80;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_ITEMS  = 1150;
    localparam int MAX_REPORTS = 10;

    // Track stored points, sums and registers; predict each fetch result
    class centroid_bond_tracker;
        int        pt_x[DEPTH];
        int        pt_y[DEPTH];
        int        pt_z[DEPTH];
        longint    sum_x, sum_y, sum_z;
        int        count;
        logic      mode;
        int        max_pts;
        ccbu_out_t pending_results[$];
        int        mismatches;
        int        results_checked;

        function new();
            sum_x = 0; sum_y = 0; sum_z = 0;
            count = 0;
            mode = MODE_CENTER;
            max_pts = int'(MAX_POINTS_RST);
            mismatches = 0;
            results_checked = 0;
        endfunction

        function void set_register(logic idx, int value);
            if (idx == REG_MODE) mode = value[0];
            else max_pts = value & 'h1FFF;
        endfunction

        // centroid coordinate: nearest, ties away from zero
        function longint centroid_coord(longint s, int n);
            longint unsigned mag;
            longint unsigned q;
            mag = (s < 0) ? -s : s;
            q = (2 * mag + n) / (2 * longint'(n));
            return (s < 0) ? -longint'(q) : longint'(q);
        endfunction

        // largest u with u*u*len2 <= d*d*2^30, sign of d
        function longint unit_part(longint d, longint unsigned len2);
            logic [127:0] mag;
            logic [127:0] q;
            longint       lo, hi, mid;
            mag = (d < 0) ? -d : d;
            q = ((mag * mag) << 30) / len2;
            lo = 0;
            hi = 32768;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (128'(mid * mid) <= q) lo = mid;
                else hi = mid - 1;
            end
            return (d < 0) ? -lo : lo;
        endfunction

        function ccbu_out_t fetch_result(int i);
            ccbu_out_t    o;
            longint       dx, dy, dz;
            longint unsigned len2;
            o = '0;
            if (mode == MODE_CENTER) begin
                if (i < count) begin
                    o.valid_res = 1'b1;
                    o.ox = COORD_W'(pt_x[i] - centroid_coord(sum_x, count));
                    o.oy = COORD_W'(pt_y[i] - centroid_coord(sum_y, count));
                    o.oz = COORD_W'(pt_z[i] - centroid_coord(sum_z, count));
                end
            end else if (i + 1 < count) begin
                dx = longint'(pt_x[i+1]) - pt_x[i];
                dy = longint'(pt_y[i+1]) - pt_y[i];
                dz = longint'(pt_z[i+1]) - pt_z[i];
                len2 = dx * dx + dy * dy + dz * dz;
                o.valid_res = 1'b1;
                if (len2 != 0) begin
                    o.ox = COORD_W'(unit_part(dx, len2));
                    o.oy = COORD_W'(unit_part(dy, len2));
                    o.oz = COORD_W'(unit_part(dz, len2));
                end
            end
            return o;
        endfunction

        function void note_request(ccbu_in_t r);
            int limit;
            if (r.req_type == REQ_LOAD) begin
                limit = (max_pts < DEPTH) ? max_pts : DEPTH;
                if (r.first) begin
                    sum_x = 0; sum_y = 0; sum_z = 0;
                    count = 0;
                end
                if (count < limit) begin
                    pt_x[count] = $signed(r.px);
                    pt_y[count] = $signed(r.py);
                    pt_z[count] = $signed(r.pz);
                    sum_x += pt_x[count];
                    sum_y += pt_y[count];
                    sum_z += pt_z[count];
                    count++;
                end
            end else begin
                pending_results.push_back(fetch_result(int'(r.fetch_index)));
            end
        endfunction

        function void check_result(ccbu_out_t got);
            ccbu_out_t want;
            results_checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: valid=%0d x=%h y=%h z=%h",
                             got.valid_res, got.ox, got.oy, got.oz);
                return;
            end
            want = pending_results.pop_front();
            if (got.valid_res !== want.valid_res || got.ox !== want.ox ||
                got.oy !== want.oy || got.oz !== want.oz) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result mismatch: want v=%0d %h %h %h got v=%0d %h %h %h",
                             want.valid_res, want.ox, want.oy, want.oz,
                             got.valid_res, got.ox, got.oy, got.oz);
            end
        endfunction
    endclass

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    ccbu_in_t            s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    ccbu_out_t           m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    centroid_bond_tracker tracker = new();

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold     = 1'b0;
    int  idle_cycles   = 0;
    int  loads_sent    = 0;
    int  fetches_sent  = 0;
    int  cfg_writes    = 0;
    int  last_x, last_y, last_z;

    coord_centering_bond_unit_vectors_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 aclk = ~aclk;

    // Stall the result side at random, or fully during a hold-off
    always @(posedge aclk) begin
        m_ready <= aresetn && !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Check results while outputs are stable; they transfer at the next edge
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_result(m_data);
    end

    // Watchdog on cycles with no transfer of any kind
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[coord_centering_bond_unit_vectors_top] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic hold_results(int cycles);
        recv_hold = 1'b1;
        repeat (cycles) @(posedge aclk);
        recv_hold = 1'b0;
    endtask

    // Offer one item after a random gap; return at the edge it transfers
    task automatic send_item(ccbu_in_t item);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        forever begin
            @(negedge aclk);
            if (s_ready) break;
        end
        @(posedge aclk);
        tracker.note_request(item);
        if (item.req_type == REQ_LOAD) loads_sent++;
        else fetches_sent++;
    endtask

    task automatic send_load(bit first, int x, int y, int z);
        ccbu_in_t item;
        item = ccbu_in_t'({$urandom, $urandom, $urandom});
        item.req_type = REQ_LOAD;
        item.first    = first;
        item.px = COORD_W'(x);
        item.py = COORD_W'(y);
        item.pz = COORD_W'(z);
        last_x = x; last_y = y; last_z = z;
        send_item(item);
    endtask

    task automatic send_fetch(int idx);
        ccbu_in_t item;
        item = ccbu_in_t'({$urandom, $urandom, $urandom});
        item.req_type    = REQ_FETCH;
        item.fetch_index = IDX_W'(idx);
        send_item(item);
    endtask

    // Wait for every expected result, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_register(idx, value);
        cfg_writes++;
        @(posedge aclk);
    endtask

    function automatic int pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 85) return int'($urandom_range(10998998)) - 999999;
        if (r < 95) return $signed(COORD_W'($urandom));
        case ($urandom_range(3))
            0: return -999999;
            1: return 9999999;
            2: return -(1 << 24);
            default: return (1 << 24) - 1;
        endcase
    endfunction

    // Well-formed point sets followed by fetches, with some noise items
    task automatic run_random(int n_items);
        int sent, npts, nfetch, k;
        ccbu_in_t junk;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 88) begin
                npts = ($urandom_range(9) == 0) ? $urandom_range(2, 40)
                                                : $urandom_range(1, 6);
                send_load(1'b1, pick_coord(), pick_coord(), pick_coord());
                for (k = 1; k < npts; k++) begin
                    if ($urandom_range(9) == 0) send_load(1'b0, last_x, last_y, last_z);
                    else send_load(1'b0, pick_coord(), pick_coord(), pick_coord());
                end
                nfetch = $urandom_range(1, 6);
                for (k = 0; k < nfetch; k++) begin
                    if ($urandom_range(9) < 8) send_fetch($urandom_range(npts));
                    else send_fetch($urandom_range(DEPTH - 1));
                end
                sent += npts + nfetch;
            end else begin
                junk = ccbu_in_t'({$urandom, $urandom, $urandom});
                send_item(junk);
                sent++;
            end
        end
    endtask

    initial begin
        logic modes[9] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        int   limits[9] = '{4096, 4096, 1, 0, 8191, 3, 4096, 2, 4096};
        int   seg;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Centering: coordinate extremes, full-width values, invalid index
        write_reg(REG_MODE, MODE_CENTER);
        write_reg(REG_MAX_POINTS, 4096);
        send_load(1'b1, -999999, 9999999, 0);
        send_load(1'b0, 9999999, -999999, -999999);
        send_load(1'b0, (1 << 24) - 1, -(1 << 24), 1);
        send_fetch(0);
        send_fetch(2);
        send_fetch(3);
        send_fetch(DEPTH - 1);
        drain();

        // Bond: normal step, zero length, last point has no bond
        write_reg(REG_MODE, MODE_BOND);
        send_load(1'b0, 5000, 5000, 5000);
        send_load(1'b0, 5000, 5000, 5000);
        send_fetch(0);
        send_fetch(2);
        send_fetch(3);
        send_fetch(4);
        drain();

        // Lowered limit keeps stored points, drops new loads
        write_reg(REG_MAX_POINTS, 2);
        send_load(1'b0, 7, 8, 9);
        send_fetch(3);
        drain();
        write_reg(REG_MODE, MODE_CENTER);
        send_load(1'b1, 1, 2, 3);
        send_load(1'b0, 4, 6, 9);
        send_load(1'b0, 100, 100, 100);
        send_fetch(1);
        send_fetch(2);
        drain();

        // Zero limit stores nothing
        write_reg(REG_MAX_POINTS, 0);
        send_load(1'b1, 11, 12, 13);
        send_fetch(0);
        drain();

        // Random part in three idling phases over several register settings
        for (seg = 0; seg < 9; seg++) begin
            if (seg < 3) begin
                send_idle_pct = 25; recv_idle_pct = 52;
            end else if (seg < 6) begin
                send_idle_pct = 52; recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;  recv_idle_pct = 0;
            end
            write_reg(REG_MODE, modes[seg]);
            write_reg(REG_MAX_POINTS, limits[seg]);
            if (seg == 6) fork hold_results(HOLD_CYCLES); join_none
            run_random(RAND_ITEMS / 9);
            drain();
        end

        $display("covered %0d loads, %0d fetches, %0d results, %0d register writes",
                 loads_sent, fetches_sent, tracker.results_checked, cfg_writes);
        $display("modes centering and bond, limits 0 to 8191, idle and stall phases");
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
            $display("[coord_centering_bond_unit_vectors_top] OK");
        end else begin
            $display("%0d mismatches, %0d results missing",
                     tracker.mismatches, tracker.pending_results.size());
            $display("[coord_centering_bond_unit_vectors_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
